// ----- rtl/lavm_pkg.sv -----
// Shared constants, types and helper functions of the look-at view matrix unit.
package lavm_pkg;

    // Word format of positions, directions and result columns
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Scaled magnitudes sit in [2^(SCALE_BITS-1), 2^SCALE_BITS)
    localparam int SCALE_BITS = 30;
    localparam int SCALE_TOP  = SCALE_BITS - 1;

    // Unit vector components: magnitude up to 2^FRAC_BITS, plus sign
    localparam int UNIT_BITS = FRAC_BITS + 1;
    localparam int UNIT_W    = UNIT_BITS + 1;

    // Vectors entering a normalizer: up to scaled direction times unit component
    localparam int MAG_BITS  = SCALE_BITS + UNIT_BITS + 1;
    localparam int VEC_BITS  = MAG_BITS + 1;
    localparam int LEAD_BITS = $clog2(MAG_BITS);

    // Sum of squares, square root and quotient sizes
    localparam int SUM_BITS   = 2 * SCALE_BITS + 2;
    localparam int ROOT_STEPS = SUM_BITS / 2;
    localparam int NUM_BITS   = SCALE_BITS + FRAC_BITS + 1;
    localparam int QUO_STEPS  = UNIT_BITS;

    // Full-width dot product sums
    localparam int DOT_BITS = 2 * WORD_BITS + 2;

    // Row codes of the result channel
    typedef logic [1:0] row_t;
    localparam row_t ROW_X = 2'd0;
    localparam row_t ROW_Y = 2'd1;
    localparam row_t ROW_Z = 2'd2;
    localparam row_t ROW_T = 2'd3;

    typedef logic [2:0][WORD_BITS-1:0]  word3_t;
    typedef logic [2:0][VEC_BITS-1:0]   vec3_t;
    typedef logic [2:0][UNIT_W-1:0]     unit3_t;
    typedef logic [2:0][SCALE_BITS:0]   lsv3_t;

    // Item context carried alongside the normalizers
    typedef struct packed {
        word3_t pos;
        word3_t dir;
        lsv3_t  ls;
        unit3_t r;
        logic   degen;
    } ctx_t;

    // Magnitude of a signed vector element
    function automatic logic [MAG_BITS-1:0] mag_of(input logic [VEC_BITS-1:0] v);
        logic [VEC_BITS-1:0] n;
        n = v[VEC_BITS-1] ? (~v + 1'b1) : v;
        return n[MAG_BITS-1:0];
    endfunction

    // Largest of three magnitudes
    function automatic logic [MAG_BITS-1:0] max3(input logic [2:0][MAG_BITS-1:0] m);
        logic [MAG_BITS-1:0] a;
        a = (m[0] > m[1]) ? m[0] : m[1];
        return (a > m[2]) ? a : m[2];
    endfunction

    // Position of the highest set bit
    function automatic logic [LEAD_BITS-1:0] lead_one(input logic [MAG_BITS-1:0] v);
        logic [LEAD_BITS-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_BITS; i++) begin
            if (v[i]) p = LEAD_BITS'(i);
        end
        return p;
    endfunction

    // Shift a magnitude so that the leading bit of the largest lands on SCALE_TOP
    function automatic logic [SCALE_BITS-1:0] scale_mag(input logic [MAG_BITS-1:0] m,
                                                       input logic [LEAD_BITS-1:0] lead);
        logic [MAG_BITS-1:0] s;
        if (lead > LEAD_BITS'(SCALE_TOP))
            s = m >> (lead - LEAD_BITS'(SCALE_TOP));
        else
            s = m << (LEAD_BITS'(SCALE_TOP) - lead);
        return s[SCALE_BITS-1:0];
    endfunction

endpackage

// ----- rtl/lavm_norm.sv -----
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
module lavm_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  lavm_pkg::vec3_t  in_vec,
    input  lavm_pkg::ctx_t   in_ctx,
    output logic             out_valid,
    output lavm_pkg::unit3_t out_unit,
    output lavm_pkg::ctx_t   out_ctx
);

    localparam int RS = lavm_pkg::ROOT_STEPS;
    localparam int QS = lavm_pkg::QUO_STEPS;
    localparam int SB = lavm_pkg::SUM_BITS;
    localparam int NB = lavm_pkg::NUM_BITS;
    localparam int QB = 2 * lavm_pkg::SCALE_BITS;

    typedef struct packed {
        lavm_pkg::ctx_t                               ctx;
        logic [2:0]                                   sgn;
        logic [2:0][lavm_pkg::MAG_BITS-1:0]           mag;
        logic [lavm_pkg::MAG_BITS-1:0]                mx;
        logic [lavm_pkg::LEAD_BITS-1:0]               lead;
    } pre_t;

    typedef struct packed {
        lavm_pkg::ctx_t                               ctx;
        logic [2:0]                                   sgn;
        logic                                         zero;
        logic [2:0][lavm_pkg::SCALE_BITS-1:0]         sc;
    } carry_t;

    typedef struct packed {
        lavm_pkg::ctx_t                               ctx;
        logic [2:0]                                   sgn;
        logic                                         zero;
        logic [RS-1:0]                                den;
    } dcar_t;

    logic   m1_valid_reg, m2_valid_reg, m3_valid_reg, m4_valid_reg, m5_valid_reg;
    pre_t   m1_reg, m2_reg, m3_reg;
    pre_t   m1_next, m2_next, m3_next;
    carry_t m4_reg, m4_next, m5_car_reg;
    logic [2:0][QB-1:0] m5_sq_reg;

    logic          root_valid_reg [0:RS];
    carry_t        root_car_reg   [0:RS];
    logic [SB-1:0] root_x_reg     [0:RS];
    logic [SB:0]   root_res_reg   [0:RS];
    logic [SB-1:0] root_x_next    [1:RS];
    logic [SB:0]   root_res_next  [1:RS];

    logic                                   div_valid_reg [0:QS];
    dcar_t                                  div_car_reg   [0:QS];
    logic [2:0][NB-1:0]                     div_rem_reg   [0:QS];
    logic [2:0][lavm_pkg::UNIT_BITS-1:0]    div_quo_reg   [0:QS];
    logic [2:0][NB-1:0]                     div_rem_next  [1:QS];
    logic [2:0][lavm_pkg::UNIT_BITS-1:0]    div_quo_next  [1:QS];
    dcar_t                                  div_car_next;
    logic [2:0][NB-1:0]                     div_rem_first;

    logic             out_valid_reg;
    lavm_pkg::unit3_t out_unit_reg, out_unit_next;
    lavm_pkg::ctx_t   out_ctx_reg;

    // Front stages: magnitudes, maximum, leading bit, scaling
    always_comb
    begin
        m1_next     = '0;
        m1_next.ctx = in_ctx;
        for (int i = 0; i < 3; i++) begin
            m1_next.sgn[i] = in_vec[i][lavm_pkg::VEC_BITS-1];
            m1_next.mag[i] = lavm_pkg::mag_of(in_vec[i]);
        end
        m2_next      = m1_reg;
        m2_next.mx   = lavm_pkg::max3(m1_reg.mag);
        m3_next      = m2_reg;
        m3_next.lead = lavm_pkg::lead_one(m2_reg.mx);
        m4_next.ctx  = m3_reg.ctx;
        m4_next.sgn  = m3_reg.sgn;
        m4_next.zero = (m3_reg.mx == '0);
        for (int i = 0; i < 3; i++) begin
            m4_next.sc[i] = lavm_pkg::scale_mag(m3_reg.mag[i], m3_reg.lead);
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 0; k < RS; k++) begin : g_root
        localparam logic [SB:0] BITV = (SB + 1)'(1) << (SB - 2 - 2 * k);
        logic [SB:0] trial;
        logic        take;
        assign trial = root_res_reg[k] + BITV;
        assign take  = ({1'b0, root_x_reg[k]} >= trial);
        assign root_x_next[k+1]   = take ? (root_x_reg[k] - trial[SB-1:0]) : root_x_reg[k];
        assign root_res_next[k+1] = take ? ((root_res_reg[k] >> 1) + BITV)
                                         : (root_res_reg[k] >> 1);
    end

    // Divider setup: rounded numerator, root as divisor
    always_comb
    begin
        div_car_next.ctx  = root_car_reg[RS].ctx;
        div_car_next.sgn  = root_car_reg[RS].sgn;
        div_car_next.zero = root_car_reg[RS].zero;
        div_car_next.den  = root_res_reg[RS][RS-1:0];
        for (int i = 0; i < 3; i++) begin
            div_rem_first[i] = NB'({root_car_reg[RS].sc[i], {lavm_pkg::FRAC_BITS{1'b0}}})
                             + NB'(root_res_reg[RS][RS-1:1]);
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar j = 0; j < QS; j++) begin : g_div
        localparam int B = QS - 1 - j;
        logic [NB-1:0] dsh;
        assign dsh = NB'(div_car_reg[j].den) << B;
        always_comb
        begin
            div_rem_next[j+1] = div_rem_reg[j];
            div_quo_next[j+1] = div_quo_reg[j];
            for (int i = 0; i < 3; i++) begin
                if (div_rem_reg[j][i] >= dsh) begin
                    div_rem_next[j+1][i]    = div_rem_reg[j][i] - dsh;
                    div_quo_next[j+1][i][B] = 1'b1;
                end
            end
        end
    end

    // Reapply signs, force zero vectors to zero
    always_comb
    begin
        for (int i = 0; i < 3; i++) begin
            if (div_car_reg[QS].zero)
                out_unit_next[i] = '0;
            else if (div_car_reg[QS].sgn[i])
                out_unit_next[i] = ~{1'b0, div_quo_reg[QS][i]} + 1'b1;
            else
                out_unit_next[i] = {1'b0, div_quo_reg[QS][i]};
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            m4_valid_reg  <= 1'b0;
            m5_valid_reg  <= 1'b0;
            for (int k = 0; k <= RS; k++) root_valid_reg[k] <= 1'b0;
            for (int j = 0; j <= QS; j++) div_valid_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            m1_valid_reg      <= in_valid;
            m2_valid_reg      <= m1_valid_reg;
            m3_valid_reg      <= m2_valid_reg;
            m4_valid_reg      <= m3_valid_reg;
            m5_valid_reg      <= m4_valid_reg;
            root_valid_reg[0] <= m5_valid_reg;
            for (int k = 0; k < RS; k++) root_valid_reg[k+1] <= root_valid_reg[k];
            div_valid_reg[0]  <= root_valid_reg[RS];
            for (int j = 0; j < QS; j++) div_valid_reg[j+1] <= div_valid_reg[j];
            out_valid_reg     <= div_valid_reg[QS];
        end
    end

    // Advance payload; hold on stall
    always_ff @(posedge clk)
    begin
        if (en) begin
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            m3_reg     <= m3_next;
            m4_reg     <= m4_next;
            m5_car_reg <= m4_reg;
            for (int i = 0; i < 3; i++) m5_sq_reg[i] <= QB'(m4_reg.sc[i]) * QB'(m4_reg.sc[i]);
            root_car_reg[0] <= m5_car_reg;
            root_x_reg[0]   <= SB'(m5_sq_reg[0]) + SB'(m5_sq_reg[1]) + SB'(m5_sq_reg[2]);
            root_res_reg[0] <= '0;
            for (int k = 0; k < RS; k++) begin
                root_car_reg[k+1] <= root_car_reg[k];
                root_x_reg[k+1]   <= root_x_next[k+1];
                root_res_reg[k+1] <= root_res_next[k+1];
            end
            div_car_reg[0] <= div_car_next;
            div_rem_reg[0] <= div_rem_first;
            div_quo_reg[0] <= '0;
            for (int j = 0; j < QS; j++) begin
                div_car_reg[j+1] <= div_car_reg[j];
                div_rem_reg[j+1] <= div_rem_next[j+1];
                div_quo_reg[j+1] <= div_quo_next[j+1];
            end
            out_unit_reg <= out_unit_next;
            out_ctx_reg  <= div_car_reg[QS].ctx;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_unit  = out_unit_reg;
    assign out_ctx   = out_ctx_reg;

endmodule

// ----- rtl/look_at_view_matrix_unit.sv -----
// Top level of the look-at view matrix unit: front scaling, two normalizers, dots, row output.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  input   | in_valid / in_stall | pos_x pos_y pos_z dir_x dir_y dir_z
//  result  | out_valid/out_stall | row_index col_right col_up col_look degenerate last_row
//
// One input item gives four result items, rows 0 to 3 in order, one per cycle while out_stall is low.
// Sustained input rate is limited by the single result port.
// Without stalls, row 0 follows the accepting edge through the input register, the front stages, two 56-stage
// normalizers with one square root bit and one quotient bit per stage, the up and dot stages, and the row sequencer.
// A result stall holds the pipeline once its last stage holds an item; nothing is dropped or repeated.
// Reset clears valid bits and the row sequencer only.
module look_at_view_matrix_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [lavm_pkg::WORD_BITS-1:0]   pos_x,
    input  logic [lavm_pkg::WORD_BITS-1:0]   pos_y,
    input  logic [lavm_pkg::WORD_BITS-1:0]   pos_z,
    input  logic [lavm_pkg::WORD_BITS-1:0]   dir_x,
    input  logic [lavm_pkg::WORD_BITS-1:0]   dir_y,
    input  logic [lavm_pkg::WORD_BITS-1:0]   dir_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       row_index,
    output logic [lavm_pkg::WORD_BITS-1:0]   col_right,
    output logic [lavm_pkg::WORD_BITS-1:0]   col_up,
    output logic [lavm_pkg::WORD_BITS-1:0]   col_look,
    output logic                             degenerate,
    output logic                             last_row
);

    localparam int WB      = lavm_pkg::WORD_BITS;
    localparam int VB      = lavm_pkg::VEC_BITS;
    localparam int DB      = lavm_pkg::DOT_BITS;
    localparam int UW      = lavm_pkg::UNIT_W;
    localparam int RP_BITS = UW + WB;
    localparam int LP_BITS = 2 * WB;
    localparam logic signed [DB:0] HALF   = (DB + 1)'(1) << (lavm_pkg::FRAC_BITS - 1);
    localparam logic signed [DB:0] SAT_HI = {{(DB + 2 - WB){1'b0}}, {(WB - 1){1'b1}}};
    localparam logic signed [DB:0] SAT_LO = {{(DB + 2 - WB){1'b1}}, {(WB - 1){1'b0}}};

    typedef struct packed {
        lavm_pkg::word3_t                          pos;
        lavm_pkg::word3_t                          dir;
        logic                                      degen;
        lavm_pkg::vec3_t                           rr;
        logic [2:0]                                dsgn;
        logic [2:0][lavm_pkg::MAG_BITS-1:0]        dmag;
        logic [lavm_pkg::MAG_BITS-1:0]             dmx;
        logic [lavm_pkg::LEAD_BITS-1:0]            dlead;
    } front_t;

    logic             adv;
    logic             ser_load;

    logic             i0_valid_reg;
    lavm_pkg::word3_t i0_pos_reg, i0_dir_reg;

    logic             f1_valid_reg, f2_valid_reg, f3_valid_reg, f4_valid_reg;
    front_t           f1_reg, f2_reg, f3_reg, f1_next, f2_next, f3_next;
    lavm_pkg::ctx_t   f4_ctx_reg, f4_ctx_next;
    lavm_pkg::vec3_t  f4_rr_reg;

    logic             n1_valid, n2_valid;
    lavm_pkg::unit3_t n1_unit, n2_unit;
    lavm_pkg::ctx_t   n1_ctx, n2_ctx, n1_ctx_r;

    logic             u1_valid_reg, u2_valid_reg;
    lavm_pkg::ctx_t   u1_ctx_reg, u2_ctx_reg;
    logic signed [VB-1:0] u1_prod_reg [4];
    lavm_pkg::vec3_t  u2_vec_reg;

    logic             d1_valid_reg, d2_valid_reg, d3_valid_reg;
    lavm_pkg::unit3_t d1_r_reg, d1_u_reg, d2_r_reg, d2_u_reg, d3_r_reg, d3_u_reg;
    lavm_pkg::word3_t d1_l_reg, d2_l_reg, d3_l_reg, d3_t_reg, d3_t_next;
    logic             d1_degen_reg, d2_degen_reg, d3_degen_reg;
    logic signed [RP_BITS-1:0] d1_pr_reg [3];
    logic signed [RP_BITS-1:0] d1_pu_reg [3];
    logic signed [LP_BITS-1:0] d1_pl_reg [3];
    logic signed [DB-1:0]      d2_sum_reg [3];

    logic               ser_busy_reg;
    lavm_pkg::row_t     ser_row_reg;
    lavm_pkg::unit3_t   ser_r_reg, ser_u_reg;
    lavm_pkg::word3_t   ser_l_reg, ser_t_reg;
    logic               ser_degen_reg;

    // Pipeline moves unless the last stage holds an item the row sequencer cannot take
    assign ser_load = !ser_busy_reg || (ser_row_reg == lavm_pkg::ROW_T && !out_stall);
    assign adv      = !d3_valid_reg || ser_load;
    assign in_stall = !adv;

    // Front: right axis source, direction magnitudes, max, leading bit, scaled direction
    always_comb
    begin
        f1_next       = '0;
        f1_next.pos   = i0_pos_reg;
        f1_next.dir   = i0_dir_reg;
        f1_next.degen = (i0_dir_reg[0] == '0) && (i0_dir_reg[2] == '0);
        f1_next.rr[0] = {{(VB - WB){i0_dir_reg[2][WB-1]}}, i0_dir_reg[2]};
        f1_next.rr[1] = '0;
        f1_next.rr[2] = ~{{(VB - WB){i0_dir_reg[0][WB-1]}}, i0_dir_reg[0]} + 1'b1;
        for (int i = 0; i < 3; i++) begin
            f1_next.dsgn[i] = i0_dir_reg[i][WB-1];
            f1_next.dmag[i] = lavm_pkg::mag_of({{(VB - WB){i0_dir_reg[i][WB-1]}},
                                                i0_dir_reg[i]});
        end
        f2_next       = f1_reg;
        f2_next.dmx   = lavm_pkg::max3(f1_reg.dmag);
        f3_next       = f2_reg;
        f3_next.dlead = lavm_pkg::lead_one(f2_reg.dmx);
        f4_ctx_next.pos   = f3_reg.pos;
        f4_ctx_next.dir   = f3_reg.dir;
        f4_ctx_next.degen = f3_reg.degen;
        f4_ctx_next.r     = '0;
        for (int i = 0; i < 3; i++) begin
            f4_ctx_next.ls[i] = {1'b0, lavm_pkg::scale_mag(f3_reg.dmag[i], f3_reg.dlead)};
            if (f3_reg.dsgn[i]) f4_ctx_next.ls[i] = ~f4_ctx_next.ls[i] + 1'b1;
        end
    end

    lavm_norm u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f4_valid_reg),
        .in_vec    (f4_rr_reg),
        .in_ctx    (f4_ctx_reg),
        .out_valid (n1_valid),
        .out_unit  (n1_unit),
        .out_ctx   (n1_ctx)
    );

    // Attach the right axis to the item
    always_comb
    begin
        n1_ctx_r   = n1_ctx;
        n1_ctx_r.r = n1_unit;
    end

    lavm_norm u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (u2_valid_reg),
        .in_vec    (u2_vec_reg),
        .in_ctx    (u2_ctx_reg),
        .out_valid (n2_valid),
        .out_unit  (n2_unit),
        .out_ctx   (n2_ctx)
    );

    // Translation row: negate, round half up, saturate
    always_comb
    begin
        logic signed [DB:0] t;
        logic signed [DB:0] sh;
        for (int k = 0; k < 3; k++) begin
            t  = HALF - {d2_sum_reg[k][DB-1], d2_sum_reg[k]};
            sh = t >>> lavm_pkg::FRAC_BITS;
            if (sh > SAT_HI)
                d3_t_next[k] = SAT_HI[WB-1:0];
            else if (sh < SAT_LO)
                d3_t_next[k] = SAT_LO[WB-1:0];
            else
                d3_t_next[k] = sh[WB-1:0];
        end
    end

    // Advance valid bits and the row sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            i0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            f4_valid_reg <= 1'b0;
            u1_valid_reg <= 1'b0;
            u2_valid_reg <= 1'b0;
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
            d3_valid_reg <= 1'b0;
            ser_busy_reg <= 1'b0;
            ser_row_reg  <= lavm_pkg::ROW_X;
        end
        else begin
            if (adv) begin
                i0_valid_reg <= in_valid;
                f1_valid_reg <= i0_valid_reg;
                f2_valid_reg <= f1_valid_reg;
                f3_valid_reg <= f2_valid_reg;
                f4_valid_reg <= f3_valid_reg;
                u1_valid_reg <= n1_valid;
                u2_valid_reg <= u1_valid_reg;
                d1_valid_reg <= n2_valid;
                d2_valid_reg <= d1_valid_reg;
                d3_valid_reg <= d2_valid_reg;
            end
            if (d3_valid_reg && ser_load) begin
                ser_busy_reg <= 1'b1;
                ser_row_reg  <= lavm_pkg::ROW_X;
            end
            else if (ser_busy_reg && !out_stall) begin
                if (ser_row_reg == lavm_pkg::ROW_T)
                    ser_busy_reg <= 1'b0;
                else
                    ser_row_reg <= ser_row_reg + 2'd1;
            end
        end
    end

    // Advance payload; hold on stall
    always_ff @(posedge clk)
    begin
        if (adv) begin
            i0_pos_reg <= {pos_z, pos_y, pos_x};
            i0_dir_reg <= {dir_z, dir_y, dir_x};
            f1_reg     <= f1_next;
            f2_reg     <= f2_next;
            f3_reg     <= f3_next;
            f4_ctx_reg <= f4_ctx_next;
            f4_rr_reg  <= f3_reg.rr;

            // Up axis source: cross of scaled direction with right axis
            u1_ctx_reg     <= n1_ctx_r;
            u1_prod_reg[0] <= VB'($signed(n1_ctx.ls[1])) * VB'($signed(n1_unit[2]));
            u1_prod_reg[1] <= VB'($signed(n1_ctx.ls[2])) * VB'($signed(n1_unit[0]));
            u1_prod_reg[2] <= VB'($signed(n1_ctx.ls[0])) * VB'($signed(n1_unit[2]));
            u1_prod_reg[3] <= VB'($signed(n1_ctx.ls[1])) * VB'($signed(n1_unit[0]));
            u2_ctx_reg     <= u1_ctx_reg;
            u2_vec_reg[0]  <= u1_prod_reg[0];
            u2_vec_reg[1]  <= u1_prod_reg[1] - u1_prod_reg[2];
            u2_vec_reg[2]  <= -u1_prod_reg[3];

            // Dot products with the position
            d1_r_reg     <= n2_ctx.r;
            d1_u_reg     <= n2_unit;
            d1_l_reg     <= n2_ctx.dir;
            d1_degen_reg <= n2_ctx.degen;
            for (int k = 0; k < 3; k++) begin
                d1_pr_reg[k] <= RP_BITS'($signed(n2_ctx.r[k]))
                              * RP_BITS'($signed(n2_ctx.pos[k]));
                d1_pu_reg[k] <= RP_BITS'($signed(n2_unit[k]))
                              * RP_BITS'($signed(n2_ctx.pos[k]));
                d1_pl_reg[k] <= LP_BITS'($signed(n2_ctx.dir[k]))
                              * LP_BITS'($signed(n2_ctx.pos[k]));
            end
            d2_r_reg      <= d1_r_reg;
            d2_u_reg      <= d1_u_reg;
            d2_l_reg      <= d1_l_reg;
            d2_degen_reg  <= d1_degen_reg;
            d2_sum_reg[0] <= DB'(d1_pr_reg[0]) + DB'(d1_pr_reg[1]) + DB'(d1_pr_reg[2]);
            d2_sum_reg[1] <= DB'(d1_pu_reg[0]) + DB'(d1_pu_reg[1]) + DB'(d1_pu_reg[2]);
            d2_sum_reg[2] <= DB'(d1_pl_reg[0]) + DB'(d1_pl_reg[1]) + DB'(d1_pl_reg[2]);
            d3_r_reg      <= d2_r_reg;
            d3_u_reg      <= d2_u_reg;
            d3_l_reg      <= d2_l_reg;
            d3_degen_reg  <= d2_degen_reg;
            d3_t_reg      <= d3_t_next;
        end
        if (d3_valid_reg && ser_load) begin
            ser_r_reg     <= d3_r_reg;
            ser_u_reg     <= d3_u_reg;
            ser_l_reg     <= d3_l_reg;
            ser_t_reg     <= d3_t_reg;
            ser_degen_reg <= d3_degen_reg;
        end
    end

    // Select the columns of the current row
    always_comb
    begin
        case (ser_row_reg)
            lavm_pkg::ROW_X,
            lavm_pkg::ROW_Y,
            lavm_pkg::ROW_Z:
            begin
                col_right = {{(WB - UW){ser_r_reg[ser_row_reg][UW-1]}}, ser_r_reg[ser_row_reg]};
                col_up    = {{(WB - UW){ser_u_reg[ser_row_reg][UW-1]}}, ser_u_reg[ser_row_reg]};
                col_look  = ser_l_reg[ser_row_reg];
            end
            default:
            begin
                col_right = ser_t_reg[0];
                col_up    = ser_t_reg[1];
                col_look  = ser_t_reg[2];
            end
        endcase
    end

    assign out_valid  = ser_busy_reg;
    assign row_index  = ser_row_reg;
    assign degenerate = ser_degen_reg;
    assign last_row   = (ser_row_reg == lavm_pkg::ROW_T);

`ifndef NO_ASSERTIONS
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && row_index != lavm_pkg::ROW_T)
        |=> (out_valid && row_index == $past(row_index) + 2'd1))
        else $error("row sequence broken");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |-> (col_right == '0 && col_up == '0))
        else $error("degenerate item with nonzero axes");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (d3_valid_reg && !adv) |=> d3_valid_reg)
        else $error("stalled item lost at pipeline end");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ser_busy_reg && ser_row_reg != lavm_pkg::ROW_T) |-> !ser_load)
        else $error("row sequencer reloaded mid item");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> i0_valid_reg)
        else $error("accepted item not captured");
`endif

endmodule

// ----- test/look_at_view_matrix_unit_tb.sv -----
// Self-checking testbench of the look-at view matrix unit with its own fixed-point predictor.
module look_at_view_matrix_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = lavm_pkg::WORD_BITS;
    localparam int FRAC_BITS = lavm_pkg::FRAC_BITS;

    typedef lavm_pkg::row_t row_t;
    localparam row_t ROW_T = lavm_pkg::ROW_T;

    localparam int N_ITEMS    = 410;
    localparam int CALM_ITEMS = 60;
    localparam int HOLD_LEN   = 400;

    typedef longint vec3_t [3];

    typedef struct {
        row_t                 row;
        logic [WORD_BITS-1:0] right;
        logic [WORD_BITS-1:0] up;
        logic [WORD_BITS-1:0] look;
        logic                 degen;
        logic                 last;
    } row_item_t;

    // Predict the four rows of a camera and hold them until they come out
    class view_matrix_board;
        row_item_t rows_due[$];
        int        errors;

        function longint mag_of_v(longint v);
            return v < 0 ? -v : v;
        endfunction

        // Scale so the largest magnitude lands in [2^29, 2^30)
        function void scale_vec(input vec3_t v, output vec3_t s);
            longint m[3];
            longint mx;
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = mag_of_v(v[i]);
                if (m[i] > mx) mx = m[i];
            end
            if (mx != 0)
            begin
                while (mx >= (64'sd1 << 30))
                begin
                    mx = mx >> 1;
                    for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
                end
                while (mx < (64'sd1 << 29))
                begin
                    mx = mx << 1;
                    for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
                end
            end
            for (int i = 0; i < 3; i++) s[i] = v[i] < 0 ? -m[i] : m[i];
        endfunction

        function longint unsigned floor_sqrt(longint unsigned x);
            longint unsigned res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt = bt >> 2;
            while (bt != 0)
            begin
                if (x >= res + bt)
                begin
                    x = x - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                    res = res >> 1;
                bt = bt >> 2;
            end
            return res;
        endfunction

        function void unit_vec(input vec3_t v, output vec3_t q);
            vec3_t s;
            longint unsigned sum, len, m;
            scale_vec(v, s);
            sum = 0;
            for (int i = 0; i < 3; i++) sum += mag_of_v(s[i]) * mag_of_v(s[i]);
            if (sum == 0)
            begin
                for (int i = 0; i < 3; i++) q[i] = 0;
                return;
            end
            len = floor_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                m = ((unsigned'(mag_of_v(s[i])) << FRAC_BITS) + len / 2) / len;
                q[i] = s[i] < 0 ? -longint'(m) : longint'(m);
            end
        endfunction

        // Negated dot product, rounded half up and saturated
        function longint neg_dot(vec3_t a, vec3_t p);
            logic signed [127:0] t, ea, ep;
            t = 0;
            for (int i = 0; i < 3; i++)
            begin
                ea = a[i];
                ep = p[i];
                t = t + ea * ep;
            end
            t = -t + (128'sd1 <<< (FRAC_BITS - 1));
            t = t >>> FRAC_BITS;
            if (t > 128'sd2147483647) return 64'sd2147483647;
            if (t < -128'sd2147483648) return -64'sd2147483648;
            return longint'(t);
        endfunction

        function void note_camera(logic [WORD_BITS-1:0] pos[3], logic [WORD_BITS-1:0] dir[3]);
            vec3_t p, l, ls, rr, r, ur, u, tr;
            logic degen;
            row_item_t e;
            for (int k = 0; k < 3; k++)
            begin
                p[k] = longint'($signed(pos[k]));
                l[k] = longint'($signed(dir[k]));
            end
            degen = (l[0] == 0 && l[2] == 0);
            rr[0] = l[2];
            rr[1] = 0;
            rr[2] = -l[0];
            unit_vec(rr, r);
            scale_vec(l, ls);
            ur[0] = ls[1] * r[2];
            ur[1] = ls[2] * r[0] - ls[0] * r[2];
            ur[2] = -ls[1] * r[0];
            unit_vec(ur, u);
            if (degen)
                for (int k = 0; k < 3; k++)
                begin
                    r[k] = 0;
                    u[k] = 0;
                end
            tr[0] = neg_dot(r, p);
            tr[1] = neg_dot(u, p);
            tr[2] = neg_dot(l, p);
            for (int k = 0; k < 4; k++)
            begin
                e.row   = row_t'(k);
                e.right = WORD_BITS'(k < 3 ? r[k] : tr[0]);
                e.up    = WORD_BITS'(k < 3 ? u[k] : tr[1]);
                e.look  = WORD_BITS'(k < 3 ? l[k] : tr[2]);
                e.degen = degen;
                e.last  = (row_t'(k) == ROW_T);
                rows_due.push_back(e);
            end
        endfunction

        function void check_row(row_item_t got);
            row_item_t e;
            if (rows_due.size() == 0)
            begin
                $error("unexpected row item, row_index %0d", got.row);
                errors++;
                return;
            end
            e = rows_due.pop_front();
            if (got.row != e.row)
            begin
                $error("row_index expected %0d got %0d", e.row, got.row);
                errors++;
            end
            if (got.right != e.right)
            begin
                $error("col_right expected %h got %h", e.right, got.right);
                errors++;
            end
            if (got.up != e.up)
            begin
                $error("col_up expected %h got %h", e.up, got.up);
                errors++;
            end
            if (got.look != e.look)
            begin
                $error("col_look expected %h got %h", e.look, got.look);
                errors++;
            end
            if (got.degen != e.degen)
            begin
                $error("degenerate expected %0b got %0b", e.degen, got.degen);
                errors++;
            end
            if (got.last != e.last)
            begin
                $error("last_row expected %0b got %0b", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [WORD_BITS-1:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
    logic [1:0] row_index;
    logic [WORD_BITS-1:0] col_right, col_up, col_look;
    logic degenerate, last_row;

    view_matrix_board board;
    bit calm;
    bit hold_done;

    look_at_view_matrix_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_index(row_index), .col_right(col_right), .col_up(col_up),
        .col_look(col_look), .degenerate(degenerate), .last_row(last_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one camera item and wait until it is taken
    task automatic send_camera(logic [WORD_BITS-1:0] px, py, pz, dx, dy, dz);
        logic [WORD_BITS-1:0] p[3], d[3];
        p = '{px, py, pz};
        d = '{dx, dy, dz};
        @(negedge clk);
        in_valid <= 1'b1;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        dir_x <= dx; dir_y <= dy; dir_z <= dz;
        do @(posedge clk); while (in_stall);
        board.note_camera(p, d);
    endtask

    // Drop valid for a random burst
    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 18);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    function automatic logic [WORD_BITS-1:0] rand_word();
        logic [WORD_BITS-1:0] w;
        w = $urandom;
        return $signed(w) >>> $urandom_range(0, 31);
    endfunction

    // Result stall: random bursts, one long hold, none near the end
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm)
                out_stall <= 1'b0;
            else if (!hold_done && board.rows_due.size() > 0)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 30)) @(negedge clk);
            end
        end
    end

    // Check each accepted row item
    initial
    begin
        row_item_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.row   = row_index;
                got.right = col_right;
                got.up    = col_up;
                got.look  = col_look;
                got.degen = degenerate;
                got.last  = last_row;
                board.check_row(got);
            end
        end
    end

    initial
    begin
        #3ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [WORD_BITS-1:0] mx, mn, v[6];
        int waited;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        {pos_x, pos_y, pos_z, dir_x, dir_y, dir_z} = '0;
        mx = {1'b0, {(WORD_BITS-1){1'b1}}};
        mn = {1'b1, {(WORD_BITS-1){1'b0}}};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero and vertical directions, extremes, single axes
        send_camera('0, '0, '0, '0, '0, '0);
        send_camera(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, 32'h0001_0000, '0);
        send_camera(mx, mn, mx, '0, mn, '0);
        send_camera('0, '0, '0, 32'h0001_0000, '0, '0);
        send_camera('0, '0, '0, '0, '0, 32'h0001_0000);
        send_camera(mx, mx, mx, mx, mx, mx);
        send_camera(mn, mn, mn, mn, mn, mn);
        send_camera(mx, mn, mx, mn, mx, mn);
        send_camera(mn, mx, mn, mx, mn, mx);
        send_camera(mx, mx, mx, mn, mn, mn);
        send_camera(32'd1, 32'hffff_ffff, 32'd1, 32'd1, 32'd0, 32'hffff_ffff);
        send_camera(32'h0000_8000, 32'hffff_8000, 32'h0000_8000, 32'd1, 32'd1, 32'd1);
        send_camera('1, '1, '1, mx, '0, '0);
        send_camera(32'h1234_5678, 32'h8765_4321, '0, 32'h0000_0001, mx, 32'h0000_0001);
        send_camera(mx, '0, mn, 32'h0003_0000, 32'hfffc_0000, 32'h0004_0000);

        // Random cameras: mostly general, some vertical directions
        for (int i = 0; i < N_ITEMS; i++)
        begin
            if (i >= N_ITEMS - CALM_ITEMS) calm = 1'b1;
            for (int k = 0; k < 6; k++)
                v[k] = ($urandom_range(0, 2) == 0) ? WORD_BITS'($urandom) : rand_word();
            if ($urandom_range(0, 15) == 0)
            begin
                v[3] = '0;
                v[5] = '0;
            end
            send_camera(v[0], v[1], v[2], v[3], v[4], v[5]);
            if (!calm && $urandom_range(0, 5) == 0) sender_gap();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (board.rows_due.size() != 0) @(posedge clk);
        waited = 0;
        while (waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
